### hw/rtl/lpfr_pkg.sv
// shared types and constants for the lru page frame replacer
package lpfr_pkg;

	localparam int PAGE_W   = 8;
	localparam int FRAME_W  = 4;
	localparam int FAULT_W  = 16;
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 32;
	localparam int RES_W    = 1 + FRAME_W + 1 + PAGE_W + FAULT_W;

	localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage

### hw/rtl/lpfr_ctrl.sv
// controller: beat handshakes and sequencing of one lookup per page reference
module lpfr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output lpfr_pkg::ctrl_cmd_t cmd
);

	lpfr_pkg::ctrl_state_t state_q, state_d;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lpfr_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = lpfr_pkg::ST_EXEC;
				end
			end
			lpfr_pkg::ST_EXEC: begin
				if (slot_free) begin
					state_d = lpfr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lpfr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			lpfr_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			lpfr_pkg::ST_EXEC: begin
				cmd.exec = slot_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpfr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

`ifndef ASSERT_OFF
	a_exec_sets_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> m_tvalid)
		else $error("result beat not presented after lookup");
	a_exec_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpfr_pkg::ST_EXEC) && m_tvalid && !m_tready |=>
		(state_q == lpfr_pkg::ST_EXEC))
		else $error("lookup ran over a pending result");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped before it was taken");
`endif

endmodule

### hw/rtl/lpfr_dp.sv
// datapath: frame table, recency ranks, fault counter and result register
module lpfr_dp #(
	parameter int FRAMES = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpfr_pkg::ctrl_cmd_t           cmd,
	input  logic [lpfr_pkg::PAGE_W-1:0]   in_page,
	output logic [lpfr_pkg::RES_W-1:0]    result
);

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam logic [RW-1:0] RANK_OLDEST = RW'(FRAMES - 1);

	logic                          valid_q [FRAMES];
	logic [lpfr_pkg::PAGE_W-1:0]   page_q  [FRAMES];
	logic [RW-1:0]                 rank_q  [FRAMES];
	logic [lpfr_pkg::FAULT_W-1:0]  faults_q;
	logic [lpfr_pkg::PAGE_W-1:0]   in_page_q;

	logic                          res_hit_q;
	logic [lpfr_pkg::FRAME_W-1:0]  res_frame_q;
	logic                          res_ev_valid_q;
	logic [lpfr_pkg::PAGE_W-1:0]   res_ev_page_q;

	logic          match_any, empty_any, victim_any;
	logic [IW-1:0] match_idx, empty_idx, victim_idx, slot;
	logic [lpfr_pkg::FAULT_W-1:0] faults_inc;

	// parallel lookup, lowest index wins
	always_comb begin
		match_any  = 1'b0;
		empty_any  = 1'b0;
		victim_any = 1'b0;
		match_idx  = '0;
		empty_idx  = '0;
		victim_idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (valid_q[i] && (page_q[i] == in_page_q)) begin
				match_any = 1'b1;
				match_idx = IW'(i);
			end
			if (!valid_q[i]) begin
				empty_any = 1'b1;
				empty_idx = IW'(i);
			end
			if (rank_q[i] == RANK_OLDEST) begin
				victim_any = 1'b1;
				victim_idx = IW'(i);
			end
		end
		if (match_any) begin
			slot = match_idx;
		end else if (empty_any) begin
			slot = empty_idx;
		end else begin
			slot = victim_any ? victim_idx : '0;
		end
		faults_inc = (faults_q == lpfr_pkg::FAULT_MAX) ? faults_q : faults_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_page_q <= in_page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++) begin
				valid_q[i] <= 1'b0;
				page_q[i]  <= '0;
				rank_q[i]  <= '0;
			end
			faults_q <= '0;
		end else if (cmd.exec) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (IW'(i) == slot) begin
					rank_q[i] <= '0;
				end else if (valid_q[i] && (!match_any || (rank_q[i] < rank_q[slot]))) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
			if (!match_any) begin
				valid_q[slot] <= 1'b1;
				page_q[slot]  <= in_page_q;
				faults_q      <= faults_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_hit_q      <= match_any;
			res_frame_q    <= lpfr_pkg::FRAME_W'(slot);
			res_ev_valid_q <= !match_any && !empty_any;
			res_ev_page_q  <= (!match_any && !empty_any) ? page_q[slot] : '0;
		end
	end

	assign result = {faults_q, res_ev_page_q, res_ev_valid_q, res_frame_q, res_hit_q};

`ifndef ASSERT_OFF
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && match_any |=> res_hit_q && !res_ev_valid_q)
		else $error("hit reported an eviction");
	a_miss_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && !match_any |=>
		(faults_q != $past(faults_q)) || ($past(faults_q) == lpfr_pkg::FAULT_MAX))
		else $error("miss did not count a fault");
	a_slot_newest: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> valid_q[$past(slot)] && (rank_q[$past(slot)] == '0))
		else $error("touched frame not most recent");
`endif

endmodule

### hw/rtl/lru_page_frame_replacer.sv
// top level of the lru page frame replacer
//
// channel  dir  fields (tdata, lowest bit first)
// s_*      in   page[7:0]
// m_*      out  hit, frame[3:0], evicted_valid, evicted_page[7:0], fault_count[15:0], pad
//
// each page reference is taken as a beat in ST_IDLE, then ST_EXEC does the parallel
// compare over all frames and the table update
// the result sits in an output register, so a new beat is taken while it waits
// a lookup only stalls when the previous result has not been taken
// arst_n empties all frames and clears ranks and the fault count
module lru_page_frame_replacer #(
	parameter int FRAMES = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lpfr_pkg::S_DATA_W-1:0]   s_tdata,   // page
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lpfr_pkg::M_DATA_W-1:0]   m_tdata    // hit, frame, evicted_valid, evicted_page, fault_count
);

	lpfr_pkg::ctrl_cmd_t cmd;
	logic [lpfr_pkg::RES_W-1:0] result;

	lpfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	lpfr_dp #(
		.FRAMES (FRAMES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_page (s_tdata[lpfr_pkg::PAGE_W-1:0]),
		.result  (result)
	);

	assign m_tdata = {{(lpfr_pkg::M_DATA_W - lpfr_pkg::RES_W){1'b0}}, result};

endmodule

### tb/tb_lru_page_frame_replacer.sv
// testbench for the lru page frame replacer: predicts every lookup and checks each result beat
`timescale 1ns / 1ps

module tb_lru_page_frame_replacer;

	localparam int FRAMES     = 4;
	localparam int STALL_LIMIT = 4000;

	// result fields, highest bit first, laid out as in m_tdata
	typedef struct packed {
		logic [lpfr_pkg::FAULT_W-1:0] fault_count;
		logic [lpfr_pkg::PAGE_W-1:0]  evicted_page;
		logic                         evicted_valid;
		logic [lpfr_pkg::FRAME_W-1:0] frame;
		logic                         hit;
	} lookup_t;

	class page_fault_scoreboard;
		bit                           resident[FRAMES];
		logic [lpfr_pkg::PAGE_W-1:0]  frame_pg[FRAMES];
		int unsigned                  age_rank[FRAMES];
		logic [lpfr_pkg::FAULT_W-1:0] faults;
		lookup_t                      expected_lookups[$];
		int                           mismatches;

		function new();
			for (int i = 0; i < FRAMES; i++) begin
				resident[i] = 1'b0;
				frame_pg[i] = '0;
				age_rank[i] = 0;
			end
			faults = '0;
			mismatches = 0;
		endfunction

		// replay one accepted page reference through the frame table
		function void note_reference(logic [lpfr_pkg::PAGE_W-1:0] pg);
			lookup_t     res;
			bit          found;
			bit          empty_found;
			int unsigned slot;
			int unsigned empty_slot;
			int unsigned limit;
			res = '0;
			found = 1'b0;
			empty_found = 1'b0;
			slot = 0;
			empty_slot = 0;
			for (int i = 0; i < FRAMES; i++) begin
				if (resident[i] && frame_pg[i] == pg && !found) begin
					found = 1'b1;
					slot = i;
				end
				if (!resident[i] && !empty_found) begin
					empty_found = 1'b1;
					empty_slot = i;
				end
			end
			if (found) begin
				res.hit = 1'b1;
				limit = age_rank[slot];
			end else begin
				if (empty_found) begin
					slot = empty_slot;
					resident[slot] = 1'b1;
				end else begin
					slot = 0;
					for (int i = 1; i < FRAMES; i++)
						if (age_rank[i] > age_rank[slot])
							slot = i;
					res.evicted_valid = 1'b1;
					res.evicted_page = frame_pg[slot];
				end
				frame_pg[slot] = pg;
				if (faults != lpfr_pkg::FAULT_MAX)
					faults = faults + 1'b1;
				limit = 256;
			end
			for (int i = 0; i < FRAMES; i++)
				if (resident[i] && i != slot && age_rank[i] < limit)
					age_rank[i] = age_rank[i] + 1;
			age_rank[slot] = 0;
			res.frame = slot[lpfr_pkg::FRAME_W-1:0];
			res.fault_count = faults;
			expected_lookups.push_back(res);
		endfunction

		function void check_result(logic [lpfr_pkg::M_DATA_W-1:0] beat);
			lookup_t got;
			lookup_t want;
			got = lookup_t'(beat[lpfr_pkg::RES_W-1:0]);
			if (expected_lookups.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", beat);
				return;
			end
			want = expected_lookups.pop_front();
			if (got.hit !== want.hit || got.frame !== want.frame ||
				got.evicted_valid !== want.evicted_valid ||
				got.evicted_page !== want.evicted_page ||
				got.fault_count !== want.fault_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: hit %0d/%0d frame %0d/%0d evict %0d/%0d ",
						"page %0d/%0d faults %0d/%0d (exp/act)"},
						want.hit, got.hit, want.frame, got.frame, want.evicted_valid,
						got.evicted_valid, want.evicted_page, got.evicted_page,
						want.fault_count, got.fault_count);
			end
		endfunction

		function int pending();
			return expected_lookups.size();
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [lpfr_pkg::S_DATA_W-1:0] s_tdata = '0;   // page
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	// hit, frame, evicted_valid, evicted_page, fault_count
	logic [lpfr_pkg::M_DATA_W-1:0] m_tdata;

	int unsigned send_idle = 0;
	int unsigned recv_stall = 0;
	int unsigned quiet_cycles = 0;

	page_fault_scoreboard sb = new();

	lru_page_frame_replacer #(.FRAMES(FRAMES)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_reference(s_tdata);
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("lru_page_frame_replacer test failed");
			$finish;
		end
	end

	task automatic send_page(input logic [lpfr_pkg::PAGE_W-1:0] pg);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pg;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_references(input int unsigned sidle, input int unsigned rstall,
		input int n);
		logic [lpfr_pkg::PAGE_W-1:0] pool[8];
		int unsigned                 pool_n;
		drain();
		send_idle = sidle;
		recv_stall = rstall;
		pool_n = 1;
		for (int k = 0; k < n; k++) begin
			// small working sets give hits, random pages give faults
			if (k % 50 == 0) begin
				pool_n = $urandom_range(8, 3);
				for (int j = 0; j < 8; j++)
					pool[j] = lpfr_pkg::PAGE_W'($urandom_range(255));
			end
			if ($urandom_range(99) < 75)
				send_page(pool[3'($urandom_range(pool_n - 1))]);
			else
				send_page(lpfr_pkg::PAGE_W'($urandom_range(255)));
		end
	endtask

	initial begin
		logic [lpfr_pkg::PAGE_W-1:0] directed[] = '{8'd0, 8'd0, 8'd255, 8'd1, 8'd2, 8'd255,
			8'd0, 8'd128, 8'd1, 8'd170, 8'd85, 8'd85, 8'd3, 8'd4, 8'd5, 8'd6, 8'd6, 8'd255,
			8'd0, 8'd128};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// page 0 against empty frames, fills, hits at each rank, eviction chain
		foreach (directed[i])
			send_page(directed[i]);

		run_references(0, 0, 350);
		run_references(46, 0, 350);
		run_references(0, 46, 350);
		run_references(36, 36, 350);

		drain();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("lru_page_frame_replacer test passed");
		else
			$display("lru_page_frame_replacer test failed");
		$finish;
	end

endmodule
